### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

### rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// action and status codes, controller states and command bundle
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

   typedef enum logic [1:0] {
      ACT_ENQUEUE    = 2'd0,
      ACT_DEQUEUE    = 2'd1,
      ACT_PEEK_FRONT = 2'd2,
      ACT_PEEK_REAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } ctrl_state_type;

   // register index, taken from byte address bit 2
   localparam logic REG_CAPACITY = 1'b0;

   localparam int unsigned CAP_W       = 5;
   localparam int unsigned CAP_RESET   = 16;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned CSR_ADDR_W  = 3;

   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // carry out the captured action
   } cmd_type;

endpackage

`default_nettype wire

### rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// sequencer: capture, execute, present result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output cfq_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   cfq_pkg::ctrl_state_type state_ff, state_in;
   logic                    accept;

   assign busy      = (state_ff == cfq_pkg::S_EXEC);
   assign rsp_valid = (state_ff == cfq_pkg::S_RESP);
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfq_pkg::S_IDLE: begin
            if (accept) state_in = cfq_pkg::S_EXEC;
         end
         cfq_pkg::S_EXEC: begin
            state_in = cfq_pkg::S_RESP;
         end
         cfq_pkg::S_RESP: begin
            state_in = accept ? cfq_pkg::S_EXEC : cfq_pkg::S_IDLE;
         end
         default: begin
            state_in = cfq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load = accept;
      cmd.exec = (state_ff == cfq_pkg::S_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_exec_gives_result, cmd.exec, rsp_valid, "execute cycle not followed by result")
   `ASSERT_SAME(a_result_after_exec, rsp_valid, $past(cmd.exec), "result without execute cycle")
   `ASSERT_NEXT(a_load_starts_exec, cmd.load, cmd.exec, "captured request not executed")

endmodule

`default_nettype wire

### rtl/cfq_dp.sv
// ----------------------------------------------------------------------------
// cfq_dp
// slot store, head and tail pointers, item count and result registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfq_dp #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cfq_pkg::cmd_type                      cmd,
   input  wire logic [1:0]                            req_action,
   input  wire logic signed [cfq_pkg::DATA_W-1:0]     req_value,
   input  wire logic                                  cfg_wr,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]      cfg_cap,
   output logic [1:0]                                 rsp_status,
   output logic signed [cfq_pkg::DATA_W-1:0]          rsp_data
);

   localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned RESET_CAP =
      (cfq_pkg::CAP_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH : cfq_pkg::CAP_RESET;

   logic signed [cfq_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];

   cfq_pkg::action_type               action_ff;
   logic signed [cfq_pkg::DATA_W-1:0] value_ff;
   logic [PTR_W-1:0]                  head_ff, head_in;
   logic [PTR_W-1:0]                  tail_ff, tail_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  cap_eff_ff, cap_eff_in;
   cfq_pkg::status_type               status_ff, status_in;
   logic                              data_en_ff, data_en_in;
   logic signed [cfq_pkg::DATA_W-1:0] rd_data_ff;

   logic             full, empty, wr_en;
   logic [CNT_W-1:0] head_inc, tail_inc;
   logic [PTR_W-1:0] head_nxt, tail_nxt, rd_addr;

   always_comb begin
      full     = (count_ff >= cap_eff_ff);
      empty    = (count_ff == '0);
      head_inc = CNT_W'(head_ff) + CNT_W'(1);
      tail_inc = CNT_W'(tail_ff) + CNT_W'(1);
      head_nxt = (head_inc >= cap_eff_ff) ? '0 : PTR_W'(head_inc);
      tail_nxt = (tail_inc >= cap_eff_ff) ? '0 : PTR_W'(tail_inc);

      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      cap_eff_in = cap_eff_ff;
      status_in  = status_ff;
      data_en_in = data_en_ff;
      wr_en      = 1'b0;
      rd_addr    = head_ff;

      if (cfg_wr) begin
         // new capacity empties the queue
         cap_eff_in = cfg_cap;
         head_in    = '0;
         tail_in    = PTR_W'(cfg_cap - CNT_W'(1));
         count_in   = '0;
      end else if (cmd.exec) begin
         status_in  = cfq_pkg::ST_OK;
         data_en_in = 1'b0;
         case (action_ff)
            cfq_pkg::ACT_ENQUEUE: begin
               if (full) begin
                  status_in = cfq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = tail_nxt;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            cfq_pkg::ACT_DEQUEUE: begin
               if (empty) begin
                  status_in = cfq_pkg::ST_EMPTY;
               end else begin
                  data_en_in = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     // last item gone: pointers back to their reset places
                     head_in = '0;
                     tail_in = PTR_W'(cap_eff_ff - CNT_W'(1));
                  end else begin
                     head_in = head_nxt;
                  end
               end
            end
            cfq_pkg::ACT_PEEK_FRONT: begin
               if (empty) status_in = cfq_pkg::ST_EMPTY;
               else data_en_in = 1'b1;
            end
            cfq_pkg::ACT_PEEK_REAR: begin
               rd_addr = tail_ff;
               if (empty) status_in = cfq_pkg::ST_EMPTY;
               else data_en_in = 1'b1;
            end
            default: begin
               status_in = cfq_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= PTR_W'(RESET_CAP - 1);
         count_ff   <= '0;
         cap_eff_ff <= CNT_W'(RESET_CAP);
         status_ff  <= cfq_pkg::ST_OK;
         data_en_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         cap_eff_ff <= cap_eff_in;
         status_ff  <= status_in;
         data_en_ff <= data_en_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= cfq_pkg::action_type'(req_action);
         value_ff  <= req_value;
      end
   end

   // slot store, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[tail_nxt] <= value_ff;
      if (cmd.exec) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_status = status_ff;
   assign rsp_data   = data_en_ff ? rd_data_ff : '0;

   `ASSERT_ALWAYS(a_count_in_range, count_ff <= cap_eff_ff, "item count above capacity")
   `ASSERT_SAME(a_empty_pointers, count_ff == '0, (head_ff == '0) && (CNT_W'(tail_ff) == cap_eff_ff - CNT_W'(1)), "empty queue with pointers off reset places")
   `ASSERT_ALWAYS(a_cap_nonzero, (cap_eff_ff != '0) && (cap_eff_ff <= CNT_W'(QUEUE_DEPTH)), "effective capacity out of range")

endmodule

`default_nettype wire

### rtl/circular_fifo_queue.sv
// sequence: the edge that takes start enters the execute state; the sequencer then moves
//   to the result state and raises the result strobe, and the transfer completes as it leaves
// a new request can be taken while the previous result is shown; busy is high in the
//   execute state, in which the slot store is written or read into its registered read port
// the receiver cannot stall: each result is shown for exactly one cycle
// reset: empty queue, head at slot 0, tail at the last slot, capacity 16
// ----------------------------------------------------------------------------
// circular_fifo_queue
// ring-buffer fifo of signed words with a configurable capacity
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_action,
   input  wire logic signed [cfq_pkg::DATA_W-1:0]     req_value,
   // result channel
   output logic                                       rsp_valid,
   output logic [1:0]                                 rsp_status,
   output logic signed [cfq_pkg::DATA_W-1:0]          rsp_data,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [cfq_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   // wide enough for both the raw register and the built depth
   localparam int unsigned CMP_W = (CNT_W > cfq_pkg::CAP_W) ? CNT_W : cfq_pkg::CAP_W;

   cfq_pkg::cmd_type          cmd;
   logic [cfq_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                      csr_write, cfg_wr;
   logic [cfq_pkg::CAP_W-1:0] new_cap;
   logic [CMP_W-1:0]          new_cap_ext, new_eff;
   logic [CNT_W-1:0]          cfg_cap;

   // register transfer completes in the access phase; pready never drops
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // only bit 2 of the byte address selects a register
   assign cfg_wr    = csr_write && (paddr[2] == cfq_pkg::REG_CAPACITY);

   // effective capacity: zero acts as one, values above the depth act as the depth
   always_comb begin
      new_cap     = pwdata[cfq_pkg::CAP_W-1:0];
      new_cap_ext = CMP_W'(new_cap);
      if (new_cap == '0) begin
         new_eff = CMP_W'(1);
      end else if (new_cap_ext > CMP_W'(QUEUE_DEPTH)) begin
         new_eff = CMP_W'(QUEUE_DEPTH);
      end else begin
         new_eff = new_cap_ext;
      end
      cfg_cap = CNT_W'(new_eff);
   end

   // raw register value, kept for read-back
   assign cap_in = cfg_wr ? new_cap : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cfq_pkg::CAP_W'(cfq_pkg::CAP_RESET);
      end else begin
         cap_ff <= cap_in;
      end
   end

   // read-back: unlisted registers read as zero
   assign prdata = (paddr[2] == cfq_pkg::REG_CAPACITY) ?
                   {{(32 - cfq_pkg::CAP_W){1'b0}}, cap_ff} : '0;

   // sequencer: capture on the request transfer, execute, then present
   cfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // pointers, count, slot store and result registers
   cfq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_action),
      .req_value  (req_value),
      .cfg_wr     (cfg_wr),
      .cfg_cap    (cfg_cap),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ring-buffer fifo: a cycle-free queue predictor
// runs beside the block, each result transfer is checked against the oldest
// prediction, and the capacity register is swept over legal and clamped values
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE_WAIT  = 4;
   localparam int unsigned PHASE_ITEMS  = 165;
   localparam int unsigned NUM_PHASES   = 10;
   localparam logic [cfq_pkg::CSR_ADDR_W-1:0] CAPACITY_ADDR = 3'd0;
   localparam logic [cfq_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR   = 3'd4;

   // ordering bias of a random stretch
   typedef enum int {
      BIAS_FILL,
      BIAS_DRAIN,
      BIAS_EVEN
   } bias_type;

   typedef struct {
      cfq_pkg::status_type status;
      logic signed [31:0]  data;
   } fifo_result_type;

   // block ports
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic                busy;
   logic [1:0]          req_action = 2'd0;
   logic signed [31:0]  req_value  = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic signed [31:0]  rsp_data;
   logic                psel       = 1'b0;
   logic                penable    = 1'b0;
   logic                pwrite     = 1'b0;
   logic [cfq_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]         pwdata     = '0;
   logic [31:0]         prdata;
   logic                pready;

   // predictor state, kept in step with every accepted transfer
   logic signed [31:0]  shadow_slots [DEPTH];
   int unsigned         shadow_head;
   int unsigned         shadow_tail;
   int unsigned         shadow_count;
   logic [4:0]          shadow_capacity;

   fifo_result_type     predicted_results [$];
   int unsigned         error_count = 0;
   int unsigned         idle_cycles = 0;

   // sender pacing: bursts of back-to-back transfers, then a gap
   int unsigned         burst_left = 0;

   circular_fifo_queue #(
      .QUEUE_DEPTH (DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // queue predictor
   // ------------------------------------------------------------------------

   // register value clamped to 1..depth
   function automatic int unsigned usable_slots();
      if (shadow_capacity < 1) return 1;
      if (shadow_capacity > DEPTH) return DEPTH;
      return shadow_capacity;
   endfunction

   function automatic int unsigned wrap_next(int unsigned p);
      int unsigned n;
      n = p + 1;
      return (n >= usable_slots()) ? 0 : n;
   endfunction

   // pointers back to their reset positions, next enqueue lands in slot 0
   function automatic void clear_queue();
      shadow_head  = 0;
      shadow_tail  = usable_slots() - 1;
      shadow_count = 0;
   endfunction

   // works out the result of one accepted action and queues it up
   function automatic void predict_action(cfq_pkg::action_type act,
                                          logic signed [31:0] word);
      fifo_result_type res;
      res.status = cfq_pkg::ST_OK;
      res.data   = '0;
      if (act == cfq_pkg::ACT_ENQUEUE) begin
         if (shadow_count >= usable_slots()) begin
            res.status = cfq_pkg::ST_FULL;
         end else begin
            shadow_tail = wrap_next(shadow_tail);
            shadow_slots[shadow_tail] = word;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         res.status = cfq_pkg::ST_EMPTY;
      end else begin
         case (act)
            cfq_pkg::ACT_DEQUEUE: begin
               res.data = shadow_slots[shadow_head];
               shadow_count--;
               if (shadow_count == 0) clear_queue();
               else shadow_head = wrap_next(shadow_head);
            end
            cfq_pkg::ACT_PEEK_FRONT: begin
               res.data = shadow_slots[shadow_head];
            end
            default: begin
               res.data = shadow_slots[shadow_tail];
            end
         endcase
      end
      predicted_results = {predicted_results, res};
   endfunction

   // ------------------------------------------------------------------------
   // result checker: the receiver never stalls, so every strobe is a transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      fifo_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (predicted_results.size() == 0) begin
            $error("result transfer with nothing predicted: status %0d data %0d",
                   rsp_status, rsp_data);
            error_count++;
         end else begin
            exp_res = predicted_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $error("rsp_status mismatch: expected %0d, actual %0d",
                      exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_data !== exp_res.data) begin
               $error("rsp_data mismatch: expected %0d, actual %0d",
                      exp_res.data, rsp_data);
               error_count++;
            end
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // one request transfer; start stays high so the next call can follow on
   task automatic send_action(cfq_pkg::action_type act, logic signed [31:0] word);
      start      <= 1'b1;
      req_action <= act;
      req_value  <= word;
      do @(posedge clock); while (busy);
      predict_action(act, word);
   endtask

   // random bursts with random gaps, the odd long unbroken stretch
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clock);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
   endtask

   // hold off the sender until every predicted result has been checked
   task automatic wait_for_results();
      start <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   // register write, only ever issued with the queue quiet
   task automatic csr_write(logic [cfq_pkg::CSR_ADDR_W-1:0] addr, logic [31:0] wdata);
      wait_for_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // index comes from address bit 2, anything but the capacity is dropped
      if (addr[2] == cfq_pkg::REG_CAPACITY) begin
         shadow_capacity = wdata[4:0];
         clear_queue();
      end
   endtask

   // capacity read-back against the predictor copy
   task automatic csr_check_capacity();
      logic [31:0] rdata;
      // leave the bus idle after the previous register transfer
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rdata[4:0] !== shadow_capacity) begin
         $error("capacity read-back mismatch: expected %0d, actual %0d",
                shadow_capacity, rdata[4:0]);
         error_count++;
      end
   endtask

   // random word with the extremes mixed in
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cfq_pkg::action_type random_action(bias_type bias);
      int unsigned enq_pct;
      int unsigned r;
      case (bias)
         BIAS_FILL:  enq_pct = 75;
         BIAS_DRAIN: enq_pct = 25;
         default:    enq_pct = 50;
      endcase
      if ($urandom_range(99) < enq_pct) return cfq_pkg::ACT_ENQUEUE;
      r = $urandom_range(3);
      if (r < 2) return cfq_pkg::ACT_DEQUEUE;
      return (r == 2) ? cfq_pkg::ACT_PEEK_FRONT : cfq_pkg::ACT_PEEK_REAR;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // refused actions on an empty queue, extremes in and out, empty rewind
   task automatic test_reset_state();
      send_action(cfq_pkg::ACT_DEQUEUE, 32'sh1234_5678);
      send_action(cfq_pkg::ACT_PEEK_FRONT, '0);
      send_action(cfq_pkg::ACT_PEEK_REAR, -32'sd1);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sh7FFF_FFFF);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sh8000_0000);
      send_action(cfq_pkg::ACT_PEEK_FRONT, '0);
      send_action(cfq_pkg::ACT_PEEK_REAR, '0);
      send_action(cfq_pkg::ACT_DEQUEUE, '0);
      send_action(cfq_pkg::ACT_DEQUEUE, '0);
      // queue emptied, so this one goes back to slot 0
      send_action(cfq_pkg::ACT_ENQUEUE, -32'sd1);
      send_action(cfq_pkg::ACT_PEEK_REAR, '0);
   endtask

   // capacity write while an item is held empties the queue; full and wrap
   task automatic test_small_capacity();
      csr_write(CAPACITY_ADDR, 32'd2);
      send_action(cfq_pkg::ACT_PEEK_FRONT, '0);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd11);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd22);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd33);
      send_action(cfq_pkg::ACT_DEQUEUE, '0);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd44);
      send_action(cfq_pkg::ACT_PEEK_REAR, '0);
      send_action(cfq_pkg::ACT_PEEK_FRONT, '0);
   endtask

   // zero capacity behaves as one slot; write to an unused index is dropped
   task automatic test_clamp_and_unused_index();
      csr_write(CAPACITY_ADDR, 32'd0);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd5);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd6);
      send_action(cfq_pkg::ACT_DEQUEUE, '0);
      csr_write(UNUSED_ADDR, 32'hFFFF_FFE3);
      csr_check_capacity();
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd7);
      send_action(cfq_pkg::ACT_ENQUEUE, 32'sd8);
   endtask

   // random traffic over a spread of capacities, extremes and clamps included
   task automatic test_random_traffic();
      int unsigned cap_sel;
      int unsigned pause_at;
      int unsigned stretch_left;
      bias_type    bias;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       cap_sel = 16;
            1:       cap_sel = 1;
            2:       cap_sel = 31;
            3:       cap_sel = 0;
            4:       cap_sel = 17;
            5:       cap_sel = 2;
            default: cap_sel = $urandom_range(0, 31);
         endcase
         // upper data bits carry noise, the register only keeps five
         csr_write(CAPACITY_ADDR,
                   {27'($urandom_range(0, 32'h07FF_FFFF)), cap_sel[4:0]});
         csr_check_capacity();
         pause_at     = $urandom_range(20, PHASE_ITEMS - 20);
         stretch_left = 0;
         bias         = BIAS_EVEN;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (stretch_left == 0) begin
               bias         = bias_type'($urandom_range(2));
               stretch_left = $urandom_range(8, 40);
            end
            stretch_left--;
            send_action(random_action(bias), random_word());
            if (n == pause_at) wait_for_results();
            else pace_sender();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      shadow_capacity = 5'(cfq_pkg::CAP_RESET);
      clear_queue();
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_small_capacity();
      test_clamp_and_unused_index();
      test_random_traffic();

      wait_for_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

### circular_fifo_queue.f
+incdir+rtl
rtl/cfq_pkg.sv
rtl/cfq_ctrl.sv
rtl/cfq_dp.sv
rtl/circular_fifo_queue.sv
tb/tb_top.sv
